### hdl/stream_kth_largest_defines.svh
// Assertion macros shared by the stream_kth_largest RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef STREAM_KTH_LARGEST_DEFINES_SVH
`define STREAM_KTH_LARGEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define SKL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define SKL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/skl_pkg.sv
// Shared types and constants for the stream_kth_largest block.
// No dependencies.
package skl_pkg;

  localparam int VALUE_W       = 32;
  localparam int K_W           = 7;
  localparam int MAX_K_DEFAULT = 64;
  // cells ORed together in the first readout stage
  localparam int GROUP_DEFAULT = 8;

  localparam logic [K_W-1:0] K_RESET = K_W'(1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [K_W-1:0]            rank_t;

  // what a cell hands to the next cell down the chain
  typedef struct packed {
    logic   keep;   // cell holds a value >= the incoming word
    logic   valid;
    value_t value;
  } skl_link_t;

endpackage

### hdl/stream_kth_largest.sv
// Streaming k-th largest: a chain of MAX_K sorted cells plus a readout tree.
// Each accepted word passes through the cell update, the group OR stage and
// the output register. One word per cycle while value_stall is low; all
// cells take the insert in parallel.
// Reset (rst, synchronous): store emptied, k_select back to 1, pipeline clear.
// Depends on skl_pkg, skl_cell, skl_readout and stream_kth_largest_defines.svh.
`include "stream_kth_largest_defines.svh"

module stream_kth_largest import skl_pkg::*; #(
  parameter int MAX_K = MAX_K_DEFAULT,
  parameter int GROUP = GROUP_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  // configuration: rank to report
  input  logic   cfg_write,
  input  rank_t  cfg_data,
  // input words
  input  logic   value_valid,
  output logic   value_stall,
  input  value_t new_value,
  // result words
  output logic   result_valid,
  input  logic   result_stall,
  output value_t kth_value,
  output logic   enough_held
);

  rank_t     k_select;
  logic      insert;
  skl_link_t link      [MAX_K+1];
  value_t    tap_value [MAX_K];
  logic      tap_hit   [MAX_K];
  logic      prefix_ok;
  logic      order_ok;

  // the user must ensure k is only rewritten while idle (left unenforced), so cells decode it directly
  always_ff @(posedge clk) begin
    if (rst) begin
      k_select <= K_RESET;
    end else if (cfg_write) begin
      k_select <= cfg_data;
    end
  end

  assign insert = value_valid && !value_stall;

  // Head of chain: behaves as a full cell that always keeps (its value field is zero),
  // so cell 0 takes the new word whenever it does not keep its own.
  assign link[0].keep  = 1'b1;
  assign link[0].valid = 1'b1;
  assign link[0].value = '0;

  // Each cell either keeps its value, takes the new word (when the cell above
  // keeps) or takes the value shifted down from above. The last cell's old
  // value simply drops out once the store is full; with the store full, a word
  // not above the smallest held value leaves every cell keeping and is discarded.
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    skl_cell #(
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .insert    (insert),
      .new_value (new_value),
      .k_select  (k_select),
      .prev      (link[i]),
      .link      (link[i+1]),
      .tap_value (tap_value[i]),
      .tap_hit   (tap_hit[i])
    );
  end

  // Only the cell at rank k drives its tap, and only when valid, so an
  // out-of-range k or too few words reads back as zero with the flag low.
  skl_readout #(
    .MAX_K (MAX_K),
    .GROUP (GROUP)
  ) u_readout (
    .clk          (clk),
    .rst          (rst),
    .insert       (insert),
    .tap_value    (tap_value),
    .tap_hit      (tap_hit),
    .busy         (value_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kth_value    (kth_value),
    .enough_held  (enough_held)
  );

  // check terms: valid cells form a prefix, held values are descending
  always_comb begin
    prefix_ok = 1'b1;
    order_ok  = 1'b1;
    for (int i = 1; i < MAX_K; i++) begin
      if (link[i+1].valid && !link[i].valid) begin
        prefix_ok = 1'b0;
      end
      if (link[i+1].valid && (link[i+1].value > link[i].value)) begin
        order_ok = 1'b0;
      end
    end
  end

  `SKL_ASSERT_IMP(a_valid_prefix, 1'b1, prefix_ok, "cell valid bits not a prefix")
  `SKL_ASSERT_IMP(a_descending, 1'b1, order_ok, "held values out of order")
  `SKL_ASSERT_NXT(a_head_filled, insert, link[1].valid, "first cell empty after insert")
  `SKL_ASSERT_IMP(a_flag_needs_word, result_valid && enough_held, k_select != '0,
                  "flag raised with zero rank")

endmodule

### hdl/skl_cell.sv
// One slot of the descending sorted chain, with its readout tap.
// Depends on skl_pkg.
module skl_cell import skl_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      insert,
  input  value_t    new_value,
  input  rank_t     k_select,
  input  skl_link_t prev,
  output skl_link_t link,
  output value_t    tap_value,
  output logic      tap_hit
);

  value_t value;
  logic   valid;
  logic   keep;
  logic   sel;

  // ties: new word goes after its equals
  assign keep = valid && (value >= new_value);
  assign sel  = (int'(k_select) == INDEX + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (insert && !keep) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (insert && !keep) begin
      value <= prev.keep ? new_value : prev.value;
    end
  end

  assign link.keep  = keep;
  assign link.valid = valid;
  assign link.value = value;

  assign tap_hit   = valid && sel;
  assign tap_value = tap_hit ? value : '0;

endmodule

### hdl/skl_readout.sv
// Two-stage registered OR tree over the cell taps, with result handshake.
// Depends on skl_pkg.
module skl_readout import skl_pkg::*; #(
  parameter int MAX_K = MAX_K_DEFAULT,
  parameter int GROUP = GROUP_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   insert,
  input  value_t tap_value [MAX_K],
  input  logic   tap_hit   [MAX_K],
  output logic   busy,
  output logic   result_valid,
  input  logic   result_stall,
  output value_t kth_value,
  output logic   enough_held
);

  localparam int NUM_GROUPS = (MAX_K + GROUP - 1) / GROUP;

  logic   pending;   // cells hold a fresh word not yet sampled
  logic   a_valid;
  logic   a_move;
  logic   out_move;
  value_t grp_value      [NUM_GROUPS];
  logic   grp_hit        [NUM_GROUPS];
  value_t grp_value_next [NUM_GROUPS];
  logic   grp_hit_next   [NUM_GROUPS];
  value_t kth_value_next;
  logic   enough_held_next;

  assign out_move = !result_valid || !result_stall;
  assign a_move   = !a_valid || out_move;
  assign busy     = pending && !a_move;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_value_next[g] = '0;
      grp_hit_next[g]   = 1'b0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < MAX_K) begin
          grp_value_next[g] = grp_value_next[g] | tap_value[g * GROUP + j];
          grp_hit_next[g]   = grp_hit_next[g] | tap_hit[g * GROUP + j];
        end
      end
    end
  end

  always_comb begin
    kth_value_next   = '0;
    enough_held_next = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      kth_value_next   = kth_value_next | grp_value[g];
      enough_held_next = enough_held_next | grp_hit[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (insert) begin
        pending <= 1'b1;
      end else if (a_move) begin
        pending <= 1'b0;
      end
      if (a_move) begin
        a_valid <= pending;
      end
      if (out_move) begin
        result_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      grp_value <= grp_value_next;
      grp_hit   <= grp_hit_next;
    end
    if (out_move) begin
      kth_value   <= kth_value_next;
      enough_held <= enough_held_next;
    end
  end

endmodule

### tb/stream_kth_largest_tb.sv
// Self-checking testbench for stream_kth_largest: directed and random words on a
// valid/stall stream, checked against an in-bench top-K predictor.
// Depends on skl_pkg and the stream_kth_largest RTL only.
`timescale 1ns / 100ps

module stream_kth_largest_tb;
  import skl_pkg::*;

  localparam int STORE_DEPTH    = MAX_K_DEFAULT;
  // two register stages after acceptance; the tail adds some margin
  localparam int RESULT_LATENCY = 2;
  localparam int TAIL_CYCLES    = RESULT_LATENCY + 8;
  // worst case is roughly 700 words, each behind a full receiver stall run and the
  // largest sender gap, plus drains between phases; this is several times that
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 60;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct {
    value_t kth;
    logic   enough;
  } kth_result_t;

  // DUT inputs, all known from time zero
  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   cfg_write    = 1'b0;
  rank_t  cfg_data     = K_RESET;
  logic   value_valid  = 1'b0;
  value_t new_value    = '0;
  logic   result_stall = 1'b0;

  logic   value_stall;
  logic   result_valid;
  value_t kth_value;
  logic   enough_held;

  // predictor state: descending list of the largest values held so far
  value_t      ranked_values [STORE_DEPTH];
  int          held_total   = 0;
  rank_t       rank_setting = K_RESET;
  kth_result_t pending_results [$];

  int          error_count  = 0;
  int unsigned cycle_count  = 0;

  // receiver stall pattern state
  int          stall_mode   = 0;
  int          stall_left   = 0;

  stream_kth_largest #(
    .MAX_K(STORE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .new_value   (new_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kth_value   (kth_value),
    .enough_held (enough_held)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake must still end the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stream_kth_largest_tb: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure: stretches of no stall, light and heavy random stall,
  // and solid stall runs, each lasting a random number of cycles.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        result_stall <= 1'b0;
      end
      1: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        result_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        result_stall <= 1'b1;
      end
    endcase
  end

  // Result checker: every accepted word is matched against the oldest
  // prediction. Values read here are the pre-edge ones, so no race with the DUT.
  always @(posedge clk) begin
    kth_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kth_value %0d, enough_held %0b",
               kth_value, enough_held);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (enough_held !== want.enough) begin
          $error("enough_held: expected %0b, got %0b", want.enough, enough_held);
          error_count++;
        end
        if (kth_value !== want.kth) begin
          $error("kth_value: expected %0d, got %0d", want.kth, kth_value);
          error_count++;
        end
      end
    end
  end

  // Insert into the descending list; a new value goes after its equals, and
  // with the list full anything not above the smallest entry falls off the end.
  function automatic void insert_ranked(input value_t word);
    int pos;
    int last;
    int i;
    pos = 0;
    while (pos < held_total && ranked_values[pos] >= word) pos++;
    if (pos >= STORE_DEPTH) return;
    last = (held_total < STORE_DEPTH) ? held_total : STORE_DEPTH - 1;
    for (i = last; i > pos; i--) ranked_values[i] = ranked_values[i-1];
    ranked_values[pos] = word;
    if (held_total < STORE_DEPTH) held_total++;
  endfunction

  // k-th largest under the current rank; rank 0, rank beyond the store and
  // too few values all read as zero with the flag clear.
  function automatic kth_result_t kth_lookup();
    kth_result_t res;
    int k;
    k = int'(rank_setting);
    if (k >= 1 && k <= STORE_DEPTH && k <= held_total) begin
      res.kth    = ranked_values[k-1];
      res.enough = 1'b1;
    end else begin
      res.kth    = '0;
      res.enough = 1'b0;
    end
    return res;
  endfunction

  // Random value: extremes, a cluster round zero, near-ties with held values
  // (so inserts land in the middle of the list) and the full range.
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2, 3: return value_t'($urandom_range(0, 16)) - 8;
      4, 5: begin
        if (held_total == 0) return value_t'($urandom());
        return ranked_values[$urandom_range(0, held_total - 1)]
               + value_t'($urandom_range(0, 2)) - 1;
      end
      default: return value_t'($urandom());
    endcase
  endfunction

  // Offer one word and predict its result once accepted. Valid is left high:
  // the caller either sends again or pauses.
  task automatic send_value(input value_t word);
    value_valid <= 1'b1;
    new_value   <= word;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    insert_ranked(word);
    pending_results.push_back(kth_lookup());
  endtask

  task automatic pause_sender(input int cycles);
    value_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender idle until every predicted result is back, then a latency tail.
  task automatic wait_results_drained();
    pause_sender(0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_rank(input rank_t k);
    cfg_write <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    cfg_write <= 1'b0;
    rank_setting = k;
  endtask

  // Bursts of random length with random gaps; max_gap of 0 means back-to-back.
  task automatic send_bursts(input int count, input int max_gap);
    int burst_left;
    int n;
    burst_left = $urandom_range(1, 12);
    for (n = 0; n < count; n++) begin
      send_value(pick_value());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if (max_gap > 0) pause_sender($urandom_range(1, max_gap));
      end
    end
  endtask

  // Flag stays clear until k values are in; extremes and a tie at zero.
  task automatic test_too_few_values();
    write_rank(rank_t'(4));
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value('0);
    send_value(-1);
    send_value(1);
    send_value('0);
    wait_results_drained();
  endtask

  // Rank zero and ranks past the store never report a value, nor does a rank above the count held.
  task automatic test_rank_out_of_range();
    write_rank(rank_t'(0));
    send_value(3);
    send_value(-3);
    wait_results_drained();
    write_rank(rank_t'(STORE_DEPTH + 1));
    send_value(VALUE_MAX);
    wait_results_drained();
    write_rank({K_W{1'b1}});
    send_value(VALUE_MIN);
    wait_results_drained();
    // in range, but far more than is held yet
    write_rank(rank_t'(STORE_DEPTH));
    send_value(7);
    wait_results_drained();
  endtask

  // Ties at the top and bottom, and the word that first makes k values held.
  task automatic test_ties_and_extremes();
    write_rank(rank_t'(1));
    send_value(VALUE_MAX);
    wait_results_drained();
    write_rank(rank_t'(2));
    send_value(VALUE_MAX);
    wait_results_drained();
    write_rank(rank_t'(held_total + 1));
    send_value(VALUE_MIN);
    wait_results_drained();
  endtask

  // Random words at the deepest rank until the store has filled.
  task automatic test_fill_store();
    write_rank(rank_t'(STORE_DEPTH));
    send_bursts(STORE_DEPTH + 6, 6);
    wait_results_drained();
  endtask

  // Full store: a value below or equal to the smallest changes nothing,
  // larger ones push the smallest out.
  task automatic test_store_full();
    send_value(VALUE_MIN);
    send_value(ranked_values[STORE_DEPTH-1]);
    send_value(ranked_values[0]);
    send_value(VALUE_MAX);
    send_value(ranked_values[STORE_DEPTH-1] + 1);
    wait_results_drained();
  endtask

  // Phases under different ranks, extremes first; every third phase runs
  // without sender gaps, and one phase stops mid-way until all results are in.
  task automatic test_random_ranks();
    int phase;
    int max_gap;
    rank_t k;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: k = rank_t'(1);
        1: k = rank_t'(STORE_DEPTH);
        2: k = rank_t'(0);
        3: k = {K_W{1'b1}};
        4: k = rank_t'($urandom_range(STORE_DEPTH + 1, (1 << K_W) - 1));
        default: k = rank_t'($urandom_range(1, STORE_DEPTH));
      endcase
      write_rank(k);
      max_gap = (phase % 3 == 0) ? 0 : 6;
      if (phase == 5) begin
        send_bursts(PHASE_WORDS / 2, max_gap);
        wait_results_drained();
        send_bursts(PHASE_WORDS / 2, max_gap);
      end else begin
        send_bursts(PHASE_WORDS, max_gap);
      end
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_too_few_values();
    test_rank_out_of_range();
    test_ties_and_extremes();
    test_fill_store();
    test_store_full();
    test_random_ranks();

    wait_results_drained();
    if (error_count == 0) begin
      $display("stream_kth_largest_tb: done, clean");
    end else begin
      $display("stream_kth_largest_tb: done, errors");
    end
    $finish;
  end

endmodule
